FILE: rtl/ker_pkg.sv
`timescale 1ns / 1ps

package ker_pkg;

    localparam int TMR_N    = 5;
    localparam int TMR_W    = 16;
    localparam int T_SEND   = 0;
    localparam int T_MAN    = 1;
    localparam int T_BATT   = 2;
    localparam int T_FAULT  = 3;
    localparam int T_TEMP   = 4;

    localparam int EV_MANUAL = 0;
    localparam int EV_BATT   = 1;
    localparam int EV_FAULT  = 2;
    localparam int EV_TEMP   = 3;

    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_WATCH_DELAY = 2'd0,
        REG_RETRY_LIMIT = 2'd1,
        REG_BACKOFF     = 2'd2,
        REG_TEMP_MARGIN = 2'd3
    } reg_idx_t;

    localparam logic [15:0] WATCH_DELAY_RST = 16'd3000;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd4;
    localparam logic [15:0] BACKOFF_RST     = 16'd6000;
    localparam logic [11:0] TEMP_MARGIN_RST = 12'd3;

    typedef enum logic [1:0] {
        MAN_IDLE   = 2'd0,
        MAN_ACTIVE = 2'd1,
        MAN_WAIT   = 2'd2,
        MAN_RAISED = 2'd3
    } man_st_t;

    typedef enum logic [1:0] {
        FLT_IDLE   = 2'd0,
        FLT_WAIT   = 2'd1,
        FLT_RAISED = 2'd2
    } flt_st_t;

    typedef enum logic [2:0] {
        BAT_IDLE     = 3'd0,
        BAT_LOW_WAIT = 3'd1,
        BAT_LOW_SENT = 3'd2,
        BAT_LOW_HELD = 3'd3,
        BAT_OK_WAIT  = 3'd4,
        BAT_OK_SENT  = 3'd5
    } bat_st_t;

    typedef enum logic [2:0] {
        TMP_IDLE      = 3'd0,
        TMP_STOP_WAIT = 3'd1,
        TMP_STOP_SENT = 3'd2,
        TMP_STOP_HELD = 3'd3,
        TMP_RUN_WAIT  = 3'd4,
        TMP_RUN_SENT  = 3'd5
    } tmp_st_t;

    typedef enum logic [1:0] {
        SND_IDLE       = 2'd0,
        SND_WAIT_MUTEX = 2'd1,
        SND_WAIT_TX    = 2'd2,
        SND_CLEAR      = 2'd3
    } snd_st_t;

    typedef logic [TMR_N-1:0][TMR_W-1:0] tmr_vec_t;

    typedef struct packed {
        logic        tick;
        logic        manual_on;
        logic [7:0]  fault_code;
        logic        fault_critical;
        logic        low_battery;
        logic        temp_stop;
        logic [11:0] temp_sample;
        logic        tx_mutex_free;
        logic        tx_busy;
        logic        tx_failed;
        logic [7:0]  link_byte;
    } ker_in_t;

    typedef struct packed {
        logic       send_request;
        logic [7:0] send_payload;
        logic       release_mutex;
        logic       store_fault;
        logic [7:0] stored_fault_code;
        logic [3:0] pending_events;
    } ker_out_t;

    typedef struct packed {
        logic [15:0] watch_delay_ticks;
        logic [3:0]  retry_limit;
        logic [15:0] backoff_ticks;
        logic [11:0] temp_rise_margin;
    } ker_cfg_t;

    typedef struct packed {
        man_st_t     man;
        flt_st_t     flt;
        bat_st_t     bat;
        tmp_st_t     tmp;
        snd_st_t     snd;
        logic [3:0]  retry;
        tmr_vec_t    tmr;
        logic [3:0]  flags;
        logic [3:0]  latched;
        logic [11:0] temp_ref;
        logic [7:0]  last_fault;
    } ker_core_t;

    typedef struct packed {
        logic       req;
        logic [7:0] payload;
        logic       rel;
    } ker_snd_out_t;

endpackage

FILE: rtl/ker_cfg.sv
`timescale 1ns / 1ps

module ker_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ker_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output ker_pkg::ker_cfg_t              cfg
);

    ker_pkg::ker_cfg_t  cfg_reg;
    ker_pkg::reg_idx_t  idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = ker_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.watch_delay_ticks <= ker_pkg::WATCH_DELAY_RST;
            cfg_reg.retry_limit       <= ker_pkg::RETRY_LIMIT_RST;
            cfg_reg.backoff_ticks     <= ker_pkg::BACKOFF_RST;
            cfg_reg.temp_rise_margin  <= ker_pkg::TEMP_MARGIN_RST;
        end else if (wr_en) begin
            unique case (idx)
                ker_pkg::REG_WATCH_DELAY: cfg_reg.watch_delay_ticks <= pwdata[15:0];
                ker_pkg::REG_RETRY_LIMIT: cfg_reg.retry_limit       <= pwdata[3:0];
                ker_pkg::REG_BACKOFF:     cfg_reg.backoff_ticks     <= pwdata[15:0];
                ker_pkg::REG_TEMP_MARGIN: cfg_reg.temp_rise_margin  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            ker_pkg::REG_WATCH_DELAY: prdata = {16'd0, cfg_reg.watch_delay_ticks};
            ker_pkg::REG_RETRY_LIMIT: prdata = {28'd0, cfg_reg.retry_limit};
            ker_pkg::REG_BACKOFF:     prdata = {16'd0, cfg_reg.backoff_ticks};
            ker_pkg::REG_TEMP_MARGIN: prdata = {20'd0, cfg_reg.temp_rise_margin};
            default:                  prdata = '0;
        endcase
    end

endmodule

FILE: rtl/ker_watch.sv
`timescale 1ns / 1ps

module ker_watch (
    input  ker_pkg::ker_in_t   item,
    input  ker_pkg::ker_cfg_t  cfg,
    input  ker_pkg::ker_core_t cur,
    output ker_pkg::ker_core_t nxt,
    output logic               store
);

    ker_pkg::tmr_vec_t tmr_dec;
    ker_pkg::flt_st_t  flt_eff;
    ker_pkg::bat_st_t  bat_eff;
    ker_pkg::tmp_st_t  tmp_eff;
    logic              temp_rise;

    always_comb begin
        for (int i = 0; i < ker_pkg::TMR_N; i++) begin
            if (item.tick && cur.tmr[i] != '0) begin
                tmr_dec[i] = cur.tmr[i] - 16'd1;
            end else begin
                tmr_dec[i] = cur.tmr[i];
            end
        end
    end

    // manual mode sends the other watchers back to idle before they run
    assign flt_eff = item.manual_on ? ker_pkg::FLT_IDLE : cur.flt;
    assign bat_eff = item.manual_on ? ker_pkg::BAT_IDLE : cur.bat;
    assign tmp_eff = item.manual_on ? ker_pkg::TMP_IDLE : cur.tmp;

    // 13-bit compare, never wraps
    assign temp_rise = {1'b0, item.temp_sample} >
                       ({1'b0, cur.temp_ref} + {1'b0, cfg.temp_rise_margin});

    always_comb begin
        store = (flt_eff == ker_pkg::FLT_RAISED) && !cur.flags[ker_pkg::EV_FAULT];
    end

    always_comb begin
        nxt     = cur;
        nxt.tmr = tmr_dec;
        nxt.flt = flt_eff;
        nxt.bat = bat_eff;
        nxt.tmp = tmp_eff;

        unique case (cur.man)
            ker_pkg::MAN_IDLE: begin
                if (item.manual_on) nxt.man = ker_pkg::MAN_ACTIVE;
            end
            ker_pkg::MAN_ACTIVE: begin
                if (!item.manual_on) begin
                    nxt.tmr[ker_pkg::T_MAN] = cfg.watch_delay_ticks;
                    nxt.man = ker_pkg::MAN_WAIT;
                end
            end
            ker_pkg::MAN_WAIT: begin
                if (item.manual_on) begin
                    nxt.man = ker_pkg::MAN_ACTIVE;
                end else if (tmr_dec[ker_pkg::T_MAN] == '0) begin
                    nxt.flags[ker_pkg::EV_MANUAL] = 1'b1;
                    nxt.man = ker_pkg::MAN_RAISED;
                end
            end
            ker_pkg::MAN_RAISED: begin
                if (!cur.flags[ker_pkg::EV_MANUAL]) nxt.man = ker_pkg::MAN_IDLE;
            end
            default: ;
        endcase

        unique case (flt_eff)
            ker_pkg::FLT_IDLE: begin
                if (item.fault_code != '0 && item.fault_critical &&
                    item.fault_code != cur.last_fault) begin
                    nxt.tmr[ker_pkg::T_FAULT] = cfg.watch_delay_ticks;
                    nxt.flt = ker_pkg::FLT_WAIT;
                end
            end
            ker_pkg::FLT_WAIT: begin
                if (tmr_dec[ker_pkg::T_FAULT] == '0) begin
                    nxt.flags[ker_pkg::EV_FAULT] = 1'b1;
                    nxt.flt = ker_pkg::FLT_RAISED;
                end
            end
            ker_pkg::FLT_RAISED: begin
                if (!cur.flags[ker_pkg::EV_FAULT]) begin
                    nxt.last_fault = item.fault_code;
                    nxt.flt = ker_pkg::FLT_IDLE;
                end
            end
            default: ;
        endcase

        unique case (bat_eff)
            ker_pkg::BAT_IDLE: begin
                if (item.low_battery) begin
                    nxt.tmr[ker_pkg::T_BATT] = cfg.watch_delay_ticks;
                    nxt.bat = ker_pkg::BAT_LOW_WAIT;
                end
            end
            ker_pkg::BAT_LOW_WAIT: begin
                if (!item.low_battery) begin
                    nxt.bat = ker_pkg::BAT_IDLE;
                end else if (tmr_dec[ker_pkg::T_BATT] == '0) begin
                    nxt.flags[ker_pkg::EV_BATT] = 1'b1;
                    nxt.bat = ker_pkg::BAT_LOW_SENT;
                end
            end
            ker_pkg::BAT_LOW_SENT: begin
                if (!cur.flags[ker_pkg::EV_BATT]) nxt.bat = ker_pkg::BAT_LOW_HELD;
            end
            ker_pkg::BAT_LOW_HELD: begin
                if (!item.low_battery) begin
                    nxt.tmr[ker_pkg::T_BATT] = cfg.watch_delay_ticks;
                    nxt.bat = ker_pkg::BAT_OK_WAIT;
                end
            end
            ker_pkg::BAT_OK_WAIT: begin
                if (item.low_battery) begin
                    nxt.bat = ker_pkg::BAT_LOW_SENT;
                end else if (tmr_dec[ker_pkg::T_BATT] == '0) begin
                    nxt.flags[ker_pkg::EV_BATT] = 1'b1;
                    nxt.bat = ker_pkg::BAT_OK_SENT;
                end
            end
            ker_pkg::BAT_OK_SENT: begin
                if (!cur.flags[ker_pkg::EV_BATT]) nxt.bat = ker_pkg::BAT_IDLE;
            end
            default: ;
        endcase

        unique case (tmp_eff)
            ker_pkg::TMP_IDLE: begin
                if (item.temp_stop) begin
                    nxt.temp_ref = item.temp_sample;
                    nxt.tmr[ker_pkg::T_TEMP] = cfg.watch_delay_ticks;
                    nxt.tmp = ker_pkg::TMP_STOP_WAIT;
                end
            end
            ker_pkg::TMP_STOP_WAIT: begin
                if (!item.temp_stop) begin
                    nxt.tmp = ker_pkg::TMP_IDLE;
                end else if (tmr_dec[ker_pkg::T_TEMP] == '0) begin
                    nxt.flags[ker_pkg::EV_TEMP] = 1'b1;
                    nxt.tmp = ker_pkg::TMP_STOP_SENT;
                end
            end
            ker_pkg::TMP_STOP_SENT: begin
                if (!cur.flags[ker_pkg::EV_TEMP]) nxt.tmp = ker_pkg::TMP_STOP_HELD;
            end
            ker_pkg::TMP_STOP_HELD: begin
                if (!item.temp_stop) begin
                    nxt.tmr[ker_pkg::T_TEMP] = cfg.watch_delay_ticks;
                    nxt.tmp = ker_pkg::TMP_RUN_WAIT;
                end else if (temp_rise) begin
                    nxt.temp_ref = item.temp_sample;
                    nxt.tmp = ker_pkg::TMP_STOP_WAIT;
                end
            end
            ker_pkg::TMP_RUN_WAIT: begin
                if (item.temp_stop) begin
                    nxt.tmp = ker_pkg::TMP_STOP_SENT;
                end else if (tmr_dec[ker_pkg::T_TEMP] == '0) begin
                    nxt.flags[ker_pkg::EV_TEMP] = 1'b1;
                    nxt.tmp = ker_pkg::TMP_RUN_SENT;
                end
            end
            ker_pkg::TMP_RUN_SENT: begin
                if (!cur.flags[ker_pkg::EV_TEMP]) nxt.tmp = ker_pkg::TMP_IDLE;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/ker_send.sv
`timescale 1ns / 1ps

module ker_send (
    input  ker_pkg::ker_in_t     item,
    input  ker_pkg::ker_cfg_t    cfg,
    input  ker_pkg::ker_core_t   cur,
    output ker_pkg::ker_core_t   nxt,
    output ker_pkg::ker_snd_out_t sout
);

    logic [3:0] retry_inc;

    assign retry_inc = cur.retry + 4'd1;

    always_comb begin
        sout.req     = (cur.snd == ker_pkg::SND_WAIT_MUTEX) && item.tx_mutex_free;
        sout.payload = sout.req ? item.link_byte : 8'd0;
        sout.rel     = (cur.snd == ker_pkg::SND_WAIT_TX) && !item.tx_busy;
    end

    always_comb begin
        nxt = cur;
        unique case (cur.snd)
            ker_pkg::SND_IDLE: begin
                if (cur.tmr[ker_pkg::T_SEND] == '0 && cur.flags != '0) begin
                    nxt.latched = cur.flags;
                    nxt.retry   = '0;
                    nxt.snd     = ker_pkg::SND_WAIT_MUTEX;
                end
            end
            ker_pkg::SND_WAIT_MUTEX: begin
                if (item.tx_mutex_free) nxt.snd = ker_pkg::SND_WAIT_TX;
            end
            ker_pkg::SND_WAIT_TX: begin
                if (!item.tx_busy) begin
                    if (item.tx_failed) begin
                        nxt.retry = retry_inc;
                        if (retry_inc < cfg.retry_limit) begin
                            nxt.snd = ker_pkg::SND_WAIT_MUTEX;
                        end else begin
                            nxt.tmr[ker_pkg::T_SEND] = cfg.backoff_ticks;
                            nxt.snd = ker_pkg::SND_IDLE;
                        end
                    end else begin
                        nxt.snd = ker_pkg::SND_CLEAR;
                    end
                end
            end
            ker_pkg::SND_CLEAR: begin
                nxt.flags = cur.flags & ~cur.latched;
                nxt.snd   = ker_pkg::SND_IDLE;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/keepalive_event_reporter.sv
`timescale 1ns / 1ps

// Keepalive event reporter.
// s_ channel: one poll step per beat (tick, watcher inputs, transmit status).
// m_ channel: exactly one result beat per poll step, in order.
// APB port: four config registers at 0x0, 0x4, 0x8, 0xC; pready tied high.
// Write config only while no poll step is in flight.
// Path: a step is captured in the input register, evaluated by the
// watcher and sender logic, and its result lands in the output register.
// Throughput: one step per cycle while the output can drain (m_ready high
// or output register empty); the single state update per step sets it.
// Stall: if m_ready is low, the result register holds and the input register
// fills; s_ready drops only when both are full.
// Reset (aresetn low, synchronous): watchers and sender go idle, all timers
// and event flags clear, config returns to defaults
// (3000, 4, 6000, 3); no beat is pending.

module keepalive_event_reporter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ker_pkg::ker_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ker_pkg::ker_out_t              m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ker_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    ker_pkg::ker_cfg_t     cfg;
    ker_pkg::ker_in_t      in_data_reg;
    logic                  in_valid_reg;
    ker_pkg::ker_out_t     out_data_reg, out_data_next;
    logic                  out_valid_reg;
    ker_pkg::ker_core_t    core_reg, core_mid, core_next;
    ker_pkg::ker_snd_out_t sout;
    logic                  store;
    logic                  adv;

    ker_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ker_watch u_watch (
        .item  (in_data_reg),
        .cfg   (cfg),
        .cur   (core_reg),
        .nxt   (core_mid),
        .store (store)
    );

    ker_send u_send (
        .item (in_data_reg),
        .cfg  (cfg),
        .cur  (core_mid),
        .nxt  (core_next),
        .sout (sout)
    );

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        out_data_next.send_request      = sout.req;
        out_data_next.send_payload      = sout.payload;
        out_data_next.release_mutex     = sout.rel;
        out_data_next.store_fault       = store;
        out_data_next.stored_fault_code = core_next.last_fault;
        out_data_next.pending_events    = core_next.flags;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            core_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
                core_reg      <= core_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
